// ===== design/bhtt_pkg.sv =====
`timescale 1ns / 1ps

package bhtt_pkg;

  // default geometry
  localparam int TrackSlotsDef   = 16;
  localparam int HistoryDepthDef = 8;

  // register reset values and indexes
  localparam logic [7:0]  FRAME_RATE_RST = 8'd30;
  localparam logic [15:0] MIN_FIT_RST    = 16'd52429;
  localparam logic        CFG_FRAME_RATE = 1'b0;
  localparam logic        CFG_MIN_FIT    = 1'b1;

  // largest frame offset used in the fit
  localparam logic [31:0] OFFSET_MAX = 32'h00FF_FFFF;

  // item kinds
  localparam logic [1:0] KIND_OBSERVE  = 2'd0;
  localparam logic [1:0] KIND_EVALUATE = 2'd1;
  localparam logic [1:0] KIND_DROP     = 2'd2;

  // result status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_ZERO_HEIGHT = 4'd1;
  localparam logic [3:0] ST_TABLE_FULL  = 4'd2;
  localparam logic [3:0] ST_NO_TRACK    = 4'd3;
  localparam logic [3:0] ST_SHORT_HIST  = 4'd4;
  localparam logic [3:0] ST_FLAT_TIME   = 4'd5;
  localparam logic [3:0] ST_FLAT_HEIGHT = 4'd6;
  localparam logic [3:0] ST_POOR_FIT    = 4'd7;
  localparam logic [3:0] ST_NOT_APPR    = 4'd8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] object_id;
    logic [31:0] frame_number;
    logic [15:0] box_height;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  status;
    logic [15:0] ttc_seconds;
    logic [3:0]  history_length;
  } out_item_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_OBS,
    OP_DROP,
    OP_OTHER,
    OP_EVAL_RES,
    OP_OLD_RD,
    OP_OLD_CAP,
    OP_SMP_RD,
    OP_SMP_MUL,
    OP_SMP_ACC,
    OP_MUL_GO,
    OP_MUL_PUT,
    OP_TTC_SAT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_OUT_LOAD
  } dp_op_e;

  // products formed by the shared multiplier
  typedef enum logic [3:0] {
    MS_STST,
    MS_SHSH,
    MS_STSH,
    MS_LHS,
    MS_QSYY,
    MS_RHS,
    MS_DEN,
    MS_NUM,
    MS_SAT
  } mul_sel_e;

  typedef struct packed {
    dp_op_e     op;
    mul_sel_e   sel;
    logic [3:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       hit;
    logic       full_hist;
    logic       scan_last;
    logic       smp_last;
    logic       mul_busy;
    logic       sxx_zero;
    logic       syy_zero;
    logic       fit_poor;
    logic       not_appr;
    logic       ttc_sat;
    logic       div_last;
  } dp_stat_t;

endpackage

// ===== design/bhtt_ctrl.sv =====
`timescale 1ns / 1ps

module bhtt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  bhtt_pkg::dp_stat_t stat_i,
  output bhtt_pkg::dp_cmd_t  cmd_o
);
  import bhtt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DISP,
    S_OLD_CAP,
    S_SMP_RD,
    S_SMP_MUL,
    S_SMP_ACC,
    S_MUL_GO,
    S_MUL_WAIT,
    S_CHK_FLAT,
    S_CHK_FIT,
    S_CHK_SAT,
    S_DIV,
    S_EV_RES,
    S_RESP
  } state_e;

  state_e     state_q;
  mul_sel_e   sel_q;
  logic [3:0] code_q;
  logic       out_valid_q;
  logic       load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign load        = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  // state, product select, status code and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= MS_STST;
      code_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_SCAN_RD;
        end
        S_SCAN_RD: state_q <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          state_q <= stat_i.scan_last ? S_DISP : S_SCAN_RD;
        end
        S_DISP: begin
          if (stat_i.kind == KIND_EVALUATE && stat_i.hit && stat_i.full_hist) begin
            state_q <= S_OLD_CAP;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_OLD_CAP: state_q <= S_SMP_RD;
        S_SMP_RD:  state_q <= S_SMP_MUL;
        S_SMP_MUL: state_q <= S_SMP_ACC;
        S_SMP_ACC: begin
          if (stat_i.smp_last) begin
            sel_q   <= MS_STST;
            state_q <= S_MUL_GO;
          end else begin
            state_q <= S_SMP_RD;
          end
        end
        S_MUL_GO: state_q <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (!stat_i.mul_busy) begin
            state_q <= S_MUL_GO;
            case (sel_q)
              MS_STST: sel_q <= MS_SHSH;
              MS_SHSH: sel_q <= MS_STSH;
              MS_STSH: state_q <= S_CHK_FLAT;
              MS_LHS:  sel_q <= MS_QSYY;
              MS_QSYY: sel_q <= MS_RHS;
              MS_RHS:  state_q <= S_CHK_FIT;
              MS_DEN:  sel_q <= MS_NUM;
              MS_NUM:  sel_q <= MS_SAT;
              default: state_q <= S_CHK_SAT;
            endcase
          end
        end
        S_CHK_FLAT: begin
          if (stat_i.sxx_zero) begin
            code_q  <= ST_FLAT_TIME;
            state_q <= S_EV_RES;
          end else if (stat_i.syy_zero) begin
            code_q  <= ST_FLAT_HEIGHT;
            state_q <= S_EV_RES;
          end else begin
            sel_q   <= MS_LHS;
            state_q <= S_MUL_GO;
          end
        end
        S_CHK_FIT: begin
          if (stat_i.fit_poor) begin
            code_q  <= ST_POOR_FIT;
            state_q <= S_EV_RES;
          end else if (stat_i.not_appr) begin
            code_q  <= ST_NOT_APPR;
            state_q <= S_EV_RES;
          end else begin
            sel_q   <= MS_DEN;
            state_q <= S_MUL_GO;
          end
        end
        S_CHK_SAT: begin
          code_q  <= ST_OK;
          state_q <= stat_i.ttc_sat ? S_EV_RES : S_DIV;
        end
        S_DIV: begin
          if (stat_i.div_last) state_q <= S_EV_RES;
        end
        S_EV_RES: state_q <= S_RESP;
        S_RESP: begin
          if (load) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.sel  = sel_q;
    cmd_o.code = ST_OK;
    case (state_q)
      S_IDLE:     if (in_valid_i) cmd_o.op = OP_LATCH;
      S_SCAN_RD:  cmd_o.op = OP_SCAN_RD;
      S_SCAN_CMP: cmd_o.op = OP_SCAN_CMP;
      S_DISP: begin
        case (stat_i.kind)
          KIND_OBSERVE: cmd_o.op = OP_OBS;
          KIND_DROP:    cmd_o.op = OP_DROP;
          KIND_EVALUATE: begin
            if (!stat_i.hit) begin
              cmd_o.op   = OP_EVAL_RES;
              cmd_o.code = ST_NO_TRACK;
            end else if (!stat_i.full_hist) begin
              cmd_o.op   = OP_EVAL_RES;
              cmd_o.code = ST_SHORT_HIST;
            end else begin
              cmd_o.op = OP_OLD_RD;
            end
          end
          default: cmd_o.op = OP_OTHER;
        endcase
      end
      S_OLD_CAP:  cmd_o.op = OP_OLD_CAP;
      S_SMP_RD:   cmd_o.op = OP_SMP_RD;
      S_SMP_MUL:  cmd_o.op = OP_SMP_MUL;
      S_SMP_ACC:  cmd_o.op = OP_SMP_ACC;
      S_MUL_GO:   cmd_o.op = OP_MUL_GO;
      S_MUL_WAIT: if (!stat_i.mul_busy) cmd_o.op = OP_MUL_PUT;
      S_CHK_SAT:  cmd_o.op = stat_i.ttc_sat ? OP_TTC_SAT : OP_DIV_INIT;
      S_DIV:      cmd_o.op = OP_DIV_STEP;
      S_EV_RES: begin
        cmd_o.op   = OP_EVAL_RES;
        cmd_o.code = code_q;
      end
      S_RESP:     if (load) cmd_o.op = OP_OUT_LOAD;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ===== design/bhtt_dp.sv =====
`timescale 1ns / 1ps

module bhtt_dp #(
  parameter int TRACK_SLOTS   = bhtt_pkg::TrackSlotsDef,
  parameter int HISTORY_DEPTH = bhtt_pkg::HistoryDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bhtt_pkg::in_item_t in_item_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_wdata_i,
  input  bhtt_pkg::dp_cmd_t  cmd_i,
  output bhtt_pkg::dp_stat_t stat_o,
  output bhtt_pkg::out_item_t out_item_o
);
  import bhtt_pkg::*;

  localparam int SW  = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int DW  = $clog2(HISTORY_DEPTH);
  localparam int CW  = $clog2(HISTORY_DEPTH + 1);
  localparam int NE  = TRACK_SLOTS * HISTORY_DEPTH;
  localparam int AW  = $clog2(NE);
  localparam int GW  = $clog2(HISTORY_DEPTH + 1);
  localparam int STW = 24 + GW;
  localparam int TTW = 48 + GW;
  localparam int SHW = 16 + GW;
  localparam int HHW = 32 + GW;
  localparam int THW = 40 + GW;

  // configuration
  logic [7:0]  frame_rate_q;
  logic [15:0] min_fit_q;

  // track table
  logic          in_use_q [TRACK_SLOTS];
  logic [CW-1:0] cnt_q    [TRACK_SLOTS];
  logic [DW-1:0] wp_q     [TRACK_SLOTS];
  logic [15:0]   obj_mem  [TRACK_SLOTS];
  logic [47:0]   smp_mem  [NE];
  logic [15:0]   obj_rd_q;
  logic [47:0]   smp_rd_q;

  // item and search
  in_item_t      item_q;
  logic [SW-1:0] scan_q;
  logic          hit_q;
  logic [SW-1:0] hit_slot_q;
  logic          free_q;
  logic [SW-1:0] free_slot_q;

  // fit accumulation
  logic [DW-1:0]  k_q;
  logic [31:0]    f0_q;
  logic [15:0]    h0_q;
  logic [23:0]    t_q;
  logic [15:0]    h_q;
  logic [47:0]    tt_q;
  logic [31:0]    hh_q;
  logic [39:0]    th_q;
  logic [STW-1:0] st_q;
  logic [TTW-1:0] stt_q;
  logic [SHW-1:0] sh_q;
  logic [HHW-1:0] shh_q;
  logic [THW-1:0] sth_q;

  // fit results
  logic [63:0]  sxx_q;
  logic [63:0]  syy_q;
  logic [63:0]  sxy_q;
  logic [63:0]  pos_q;
  logic         appr_q;
  logic [127:0] lhs_q;
  logic [63:0]  qsyy_q;
  logic [127:0] rhs_q;
  logic [63:0]  den_q;
  logic [127:0] num_q;
  logic [127:0] satv_q;
  logic [127:0] dsh_q;
  logic [3:0]   dcnt_q;
  logic [15:0]  ttc_q;

  // shared multiplier
  logic [63:0]  ma_q;
  logic [63:0]  mb_q;
  logic [127:0] mp_q;
  logic [63:0]  pp_q;
  logic [1:0]   psh_q;
  logic [2:0]   mstep_q;
  logic         mbusy_q;
  mul_sel_e     msel_q;

  out_item_t res_q;
  out_item_t out_q;

  // combinational helpers
  logic [SW-1:0] slot;
  logic          new_track;
  logic [DW-1:0] wpos;
  logic [CW-1:0] old_cnt;
  logic [CW-1:0] new_cnt;
  logic [DW-1:0] newest;
  logic [AW-1:0] base;
  logic [AW-1:0] raddr;
  logic          smp_we;
  logic [AW-1:0] waddr;
  logic          obj_we;
  logic [31:0]   t32;
  logic [23:0]   tsat;
  logic [CW-1:0] hit_cnt;
  logic [63:0]   mul_a;
  logic [63:0]   mul_b;
  logic [31:0]   pa;
  logic [31:0]   pb;

  assign slot      = hit_q ? hit_slot_q : free_slot_q;
  assign new_track = !hit_q;
  assign wpos      = new_track ? '0 : wp_q[slot];
  assign old_cnt   = new_track ? '0 : cnt_q[slot];
  assign new_cnt   = (old_cnt == CW'(HISTORY_DEPTH)) ? old_cnt : old_cnt + 1'b1;
  assign base      = AW'(AW'(hit_slot_q) * AW'(HISTORY_DEPTH));
  assign newest    = (wp_q[hit_slot_q] == '0) ? DW'(HISTORY_DEPTH - 1)
                                              : wp_q[hit_slot_q] - 1'b1;
  assign hit_cnt   = hit_q ? cnt_q[hit_slot_q] : '0;
  assign waddr     = AW'(AW'(slot) * AW'(HISTORY_DEPTH) + AW'(wpos));
  assign smp_we    = (cmd_i.op == OP_OBS) && (item_q.box_height != '0)
                     && (hit_q || free_q);
  assign obj_we    = smp_we && new_track;
  assign raddr     = (cmd_i.op == OP_OLD_RD) ? AW'(base + AW'(wp_q[hit_slot_q]))
                                             : AW'(base + AW'(k_q));
  assign t32       = smp_rd_q[47:16] - f0_q;
  assign tsat      = (t32 > OFFSET_MAX) ? OFFSET_MAX[23:0] : t32[23:0];
  assign pa        = mstep_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign pb        = mstep_q[0] ? mb_q[63:32] : mb_q[31:0];

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.sel)
      MS_STST: begin mul_a = 64'(st_q);  mul_b = 64'(st_q); end
      MS_SHSH: begin mul_a = 64'(sh_q);  mul_b = 64'(sh_q); end
      MS_STSH: begin mul_a = 64'(st_q);  mul_b = 64'(sh_q); end
      MS_LHS:  begin mul_a = sxy_q;      mul_b = sxy_q; end
      MS_QSYY: begin mul_a = 64'(min_fit_q); mul_b = syy_q; end
      MS_RHS:  begin mul_a = sxx_q;      mul_b = qsyy_q; end
      MS_DEN:  begin mul_a = sxy_q;      mul_b = 64'(frame_rate_q); end
      MS_NUM:  begin mul_a = {40'b0, h0_q, 8'b0}; mul_b = sxx_q; end
      MS_SAT:  begin mul_a = den_q;      mul_b = 64'd65535; end
      default: begin mul_a = '0;         mul_b = '0; end
    endcase
  end

  // object and sample memories
  always_ff @(posedge clk_i) begin
    if (obj_we) obj_mem[slot] <= item_q.object_id;
    obj_rd_q <= obj_mem[scan_q];
  end

  always_ff @(posedge clk_i) begin
    if (smp_we) smp_mem[waddr] <= {item_q.frame_number, item_q.box_height};
    smp_rd_q <= smp_mem[raddr];
  end

  // status to the controller
  always_comb begin
    stat_o.kind      = item_q.kind;
    stat_o.hit       = hit_q;
    stat_o.full_hist = cnt_q[hit_slot_q] == CW'(HISTORY_DEPTH);
    stat_o.scan_last = scan_q == SW'(TRACK_SLOTS - 1);
    stat_o.smp_last  = k_q == DW'(HISTORY_DEPTH - 1);
    stat_o.mul_busy  = mbusy_q;
    stat_o.sxx_zero  = sxx_q == '0;
    stat_o.syy_zero  = syy_q == '0;
    stat_o.fit_poor  = lhs_q < rhs_q;
    stat_o.not_appr  = !appr_q;
    stat_o.ttc_sat   = (den_q == '0) || (num_q >= satv_q);
    stat_o.div_last  = dcnt_q == 4'd15;
  end

  assign out_item_o = out_q;

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rate_q <= FRAME_RATE_RST;
      min_fit_q    <= MIN_FIT_RST;
      for (int i = 0; i < TRACK_SLOTS; i++) begin
        in_use_q[i] <= 1'b0;
        cnt_q[i]    <= '0;
        wp_q[i]     <= '0;
      end
      item_q <= '0;     scan_q <= '0;      hit_q <= 1'b0;    hit_slot_q <= '0;
      free_q <= 1'b0;   free_slot_q <= '0; k_q <= '0;        f0_q <= '0;
      h0_q <= '0;       t_q <= '0;         h_q <= '0;        tt_q <= '0;
      hh_q <= '0;       th_q <= '0;        st_q <= '0;       stt_q <= '0;
      sh_q <= '0;       shh_q <= '0;       sth_q <= '0;      sxx_q <= '0;
      syy_q <= '0;      sxy_q <= '0;       pos_q <= '0;      appr_q <= 1'b0;
      lhs_q <= '0;      qsyy_q <= '0;      rhs_q <= '0;      den_q <= '0;
      num_q <= '0;      satv_q <= '0;      dsh_q <= '0;      dcnt_q <= '0;
      ttc_q <= '0;      ma_q <= '0;        mb_q <= '0;       mp_q <= '0;
      pp_q <= '0;       psh_q <= '0;       mstep_q <= '0;    mbusy_q <= 1'b0;
      msel_q <= MS_STST; res_q <= '0;      out_q <= '0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_FRAME_RATE) frame_rate_q <= cfg_wdata_i[7:0];
        if (cfg_index_i == CFG_MIN_FIT)    min_fit_q    <= cfg_wdata_i;
      end

      // multiplier: one 32x32 partial product a cycle, registered in pp_q and then added into mp_q
      if (mbusy_q) begin
        if (mstep_q != 3'd4) begin
          pp_q  <= 64'(pa) * 64'(pb);
          psh_q <= {1'b0, mstep_q[1]} + {1'b0, mstep_q[0]};
        end
        if (mstep_q != 3'd0) begin
          mp_q <= mp_q + ({64'b0, pp_q} << {psh_q, 5'b0});
        end
        if (mstep_q == 3'd4) mbusy_q <= 1'b0;
        mstep_q <= mstep_q + 1'b1;
      end

      case (cmd_i.op)
        OP_LATCH: begin
          item_q <= in_item_i;
          scan_q <= '0;
          hit_q  <= 1'b0;
          free_q <= 1'b0;
        end
        OP_SCAN_CMP: begin
          if (in_use_q[scan_q] && obj_rd_q == item_q.object_id && !hit_q) begin
            hit_q      <= 1'b1;
            hit_slot_q <= scan_q;
          end
          if (!in_use_q[scan_q] && !free_q) begin
            free_q      <= 1'b1;
            free_slot_q <= scan_q;
          end
          if (scan_q != SW'(TRACK_SLOTS - 1)) scan_q <= scan_q + 1'b1;
        end
        OP_OBS: begin
          res_q <= '0;
          if (item_q.box_height == '0) begin
            res_q.status         <= ST_ZERO_HEIGHT;
            res_q.history_length <= 4'(hit_cnt);
          end else if (hit_q || free_q) begin
            in_use_q[slot] <= 1'b1;
            cnt_q[slot]    <= new_cnt;
            wp_q[slot]     <= (wpos == DW'(HISTORY_DEPTH - 1)) ? '0 : wpos + 1'b1;
            res_q.accepted       <= 1'b1;
            res_q.history_length <= 4'(new_cnt);
          end else begin
            res_q.status <= ST_TABLE_FULL;
          end
        end
        OP_DROP: begin
          res_q <= '0;
          if (hit_q) begin
            in_use_q[hit_slot_q] <= 1'b0;
            cnt_q[hit_slot_q]    <= '0;
            res_q.accepted       <= 1'b1;
          end else begin
            res_q.status <= ST_NO_TRACK;
          end
        end
        OP_OTHER: begin
          res_q                <= '0;
          res_q.history_length <= 4'(hit_cnt);
        end
        OP_EVAL_RES: begin
          res_q.accepted       <= cmd_i.code == ST_OK;
          res_q.status         <= cmd_i.code;
          res_q.ttc_seconds    <= (cmd_i.code == ST_OK) ? ttc_q : '0;
          res_q.history_length <= 4'(hit_cnt);
        end
        OP_OLD_CAP: begin
          f0_q  <= smp_rd_q[47:16];
          k_q   <= '0;
          st_q  <= '0;
          stt_q <= '0;
          sh_q  <= '0;
          shh_q <= '0;
          sth_q <= '0;
        end
        OP_SMP_MUL: begin
          t_q  <= tsat;
          h_q  <= smp_rd_q[15:0];
          tt_q <= {24'b0, tsat} * {24'b0, tsat};
          hh_q <= {16'b0, smp_rd_q[15:0]} * {16'b0, smp_rd_q[15:0]};
          th_q <= {16'b0, tsat} * {24'b0, smp_rd_q[15:0]};
          if (k_q == newest) h0_q <= smp_rd_q[15:0];
        end
        OP_SMP_ACC: begin
          st_q  <= st_q + STW'(t_q);
          stt_q <= stt_q + TTW'(tt_q);
          sh_q  <= sh_q + SHW'(h_q);
          shh_q <= shh_q + HHW'(hh_q);
          sth_q <= sth_q + THW'(th_q);
          if (k_q != DW'(HISTORY_DEPTH - 1)) k_q <= k_q + 1'b1;
        end
        OP_MUL_GO: begin
          ma_q    <= mul_a;
          mb_q    <= mul_b;
          mp_q    <= '0;
          mstep_q <= '0;
          mbusy_q <= 1'b1;
          msel_q  <= cmd_i.sel;
        end
        OP_MUL_PUT: begin
          case (msel_q)
            MS_STST: begin
              sxx_q <= 64'(stt_q) * 64'(HISTORY_DEPTH) - mp_q[63:0];
              pos_q <= 64'(sth_q) * 64'(HISTORY_DEPTH);
            end
            MS_SHSH: syy_q <= 64'(shh_q) * 64'(HISTORY_DEPTH) - mp_q[63:0];
            MS_STSH: begin
              sxy_q  <= (pos_q >= mp_q[63:0]) ? pos_q - mp_q[63:0]
                                              : mp_q[63:0] - pos_q;
              appr_q <= pos_q > mp_q[63:0];
            end
            MS_LHS:  lhs_q  <= mp_q << 16;
            MS_QSYY: qsyy_q <= mp_q[63:0];
            MS_RHS:  rhs_q  <= mp_q;
            MS_DEN:  den_q  <= mp_q[63:0];
            MS_NUM:  num_q  <= mp_q;
            MS_SAT:  satv_q <= mp_q;
            default: satv_q <= mp_q;
          endcase
        end
        OP_TTC_SAT: ttc_q <= 16'hFFFF;
        OP_DIV_INIT: begin
          dsh_q  <= {49'b0, den_q, 15'b0};
          dcnt_q <= '0;
          ttc_q  <= '0;
        end
        OP_DIV_STEP: begin
          // restoring division, one quotient bit a cycle
          if (num_q >= dsh_q) begin
            num_q <= num_q - dsh_q;
            ttc_q <= {ttc_q[14:0], 1'b1};
          end else begin
            ttc_q <= {ttc_q[14:0], 1'b0};
          end
          dsh_q  <= dsh_q >> 1;
          dcnt_q <= dcnt_q + 1'b1;
        end
        OP_OUT_LOAD: out_q <= res_q;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/box_height_ttc_tracker_core.sv =====
`timescale 1ns / 1ps

// time to collision tracker for bounding box heights
// input channel (in_valid_i / in_ready_o / in_item_i): one item observes a sample,
// evaluates a track's collision time or drops a track; each item gives one result
// output channel (out_valid_o / out_ready_i / out_item_o): one result per item, in order
// configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i (0 frame rate,
// 1 minimum fit quality); write only while the block is idle
// one item is worked on at a time. every item first scans the track table, reading each
// slot from the object memory and comparing it, one slot after another
// observe, drop and evaluate items rejected before the fit then pass the dispatch and
// response states, and the next item is taken once the result is loaded
// a full evaluate then reads and accumulates the stored samples, forms nine wide products
// in turn on the shared 32x32 multiplier, runs the flat, fit and saturation checks and
// a restoring division for the 16 quotient bits; the division is skipped when the
// collision time saturates
// the next item is taken as soon as the result sits in the output register, so a
// stalled receiver only blocks once a second result is ready
// reset empties the track table and restores the register defaults; sample and
// object memories keep their contents and are only read after being written
module box_height_ttc_tracker_core #(
  parameter int TRACK_SLOTS   = bhtt_pkg::TrackSlotsDef,
  parameter int HISTORY_DEPTH = bhtt_pkg::HistoryDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bhtt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bhtt_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_wdata_i
);
  import bhtt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  bhtt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // track table, fit arithmetic and result registers
  bhtt_dp #(
    .TRACK_SLOTS   (TRACK_SLOTS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== tb/box_height_ttc_tracker_core_tb.sv =====
`timescale 1ns / 1ps

module box_height_ttc_tracker_core_tb;
  import bhtt_pkg::*;

  localparam int Slots = 16;
  localparam int Depth = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  // predictor state
  logic [7:0]  rate_q;
  logic [15:0] min_fit_q;
  logic        used_q [Slots];
  logic [15:0] object_q [Slots];
  logic [3:0]  count_q [Slots];
  logic [31:0] frames_q [Slots][Depth];
  logic [15:0] heights_q [Slots][Depth];

  out_item_t expected_results [$];
  int        mismatches = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  always #10 clk_i = ~clk_i;

  box_height_ttc_tracker_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // least squares time to collision of one full track
  function automatic logic [3:0] fit_status(input int s, output logic [15:0] ttc);
    logic [63:0]  st, stt, sh, shh, sth, t, h, sxx, syy, pos, neg, sxy, den;
    logic [127:0] lhs, rhs, num, rem;
    logic [31:0]  d32;
    logic [15:0]  q;
    st = 0; stt = 0; sh = 0; shh = 0; sth = 0; ttc = '0; q = '0;
    for (int i = 0; i < Depth; i++) begin
      // offset modulo 2^32 before widening
      d32 = frames_q[s][i] - frames_q[s][Depth-1];
      t = 64'(d32);
      if (t > 64'(OFFSET_MAX)) t = 64'(OFFSET_MAX);
      h = 64'(heights_q[s][i]);
      st += t; stt += t * t; sh += h; shh += h * h; sth += t * h;
    end
    sxx = Depth * stt - st * st;
    syy = Depth * shh - sh * sh;
    pos = Depth * sth;
    neg = st * sh;
    if (sxx == 0) return ST_FLAT_TIME;
    if (syy == 0) return ST_FLAT_HEIGHT;
    sxy = pos >= neg ? pos - neg : neg - pos;
    lhs = (128'(sxy) * 128'(sxy)) << 16;
    rhs = 128'(sxx) * 128'(64'(min_fit_q) * syy);
    if (lhs < rhs) return ST_POOR_FIT;
    if (pos <= neg) return ST_NOT_APPR;
    den = sxy * 64'(rate_q);
    num = 128'(64'(heights_q[s][0]) * 256) * 128'(sxx);
    if (den == 0 || num >= 128'(den) * 128'(65535)) begin
      ttc = 16'hFFFF;
      return ST_OK;
    end
    rem = num;
    for (int i = 15; i >= 0; i--) begin
      if (rem >= (128'(den) << i)) begin
        rem -= 128'(den) << i;
        q[i] = 1'b1;
      end
    end
    ttc = q;
    return ST_OK;
  endfunction

  // tracker behaviour for one item
  function automatic out_item_t track_result(input in_item_t it);
    out_item_t r;
    int s;
    logic [3:0] n;
    r = '0;
    s = -1;
    for (int i = 0; i < Slots; i++)
      if (s < 0 && used_q[i] && object_q[i] == it.object_id) s = i;
    case (it.kind)
      KIND_OBSERVE: begin
        if (it.box_height == 0) begin
          r.status = ST_ZERO_HEIGHT;
          r.history_length = s >= 0 ? count_q[s] : 4'd0;
        end else begin
          if (s < 0) begin
            for (int i = 0; i < Slots; i++)
              if (s < 0 && !used_q[i]) s = i;
            if (s >= 0) begin
              used_q[s] = 1'b1;
              object_q[s] = it.object_id;
              count_q[s] = '0;
            end
          end
          if (s < 0) begin
            r.status = ST_TABLE_FULL;
          end else begin
            n = count_q[s] >= Depth ? 4'(Depth - 1) : count_q[s];
            for (int k = Depth - 1; k > 0; k--)
              if (k <= n) begin
                frames_q[s][k] = frames_q[s][k-1];
                heights_q[s][k] = heights_q[s][k-1];
              end
            frames_q[s][0] = it.frame_number;
            heights_q[s][0] = it.box_height;
            if (count_q[s] < Depth) count_q[s]++;
            r.accepted = 1'b1;
            r.history_length = count_q[s];
          end
        end
      end
      KIND_EVALUATE: begin
        if (s < 0) begin
          r.status = ST_NO_TRACK;
        end else begin
          r.history_length = count_q[s];
          if (count_q[s] < Depth) r.status = ST_SHORT_HIST;
          else r.status = fit_status(s, r.ttc_seconds);
          r.accepted = r.status == ST_OK;
          if (!r.accepted) r.ttc_seconds = '0;
        end
      end
      KIND_DROP: begin
        if (s < 0) begin
          r.status = ST_NO_TRACK;
        end else begin
          used_q[s] = 1'b0;
          count_q[s] = '0;
          r.accepted = 1'b1;
        end
      end
      default: r.history_length = s >= 0 ? count_q[s] : 4'd0;
    endcase
    return r;
  endfunction

  // send one item, predicting its result on acceptance; valid stays up for the next
  task automatic send_item(input logic [1:0] kind, input logic [15:0] id,
                           input logic [31:0] frame, input logic [15:0] height);
    in_item_t it;
    it = '{kind: kind, object_id: id, frame_number: frame, box_height: height};
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(track_result(it));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_FRAME_RATE) rate_q = val[7:0];
    else min_fit_q = val;
  endtask

  // receiver stalls and result check
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item", 32'(out_item_o), 0);
        end else begin
          want = expected_results.pop_front();
          if (out_item_o.accepted !== want.accepted)
            report_mismatch("accepted", 32'(out_item_o.accepted), 32'(want.accepted));
          if (out_item_o.status !== want.status)
            report_mismatch("status", 32'(out_item_o.status), 32'(want.status));
          if (out_item_o.ttc_seconds !== want.ttc_seconds)
            report_mismatch("ttc_seconds", 32'(out_item_o.ttc_seconds),
                            32'(want.ttc_seconds));
          if (out_item_o.history_length !== want.history_length)
            report_mismatch("history_length", 32'(out_item_o.history_length),
                            32'(want.history_length));
        end
      end
      out_ready_i <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // one track, usually approaching: height mostly grows with frames (the base step may be negative), plus noise
  task automatic send_sequence(input logic [15:0] id, input int noise, output int count);
    logic [31:0] frame;
    logic [15:0] height;
    int step, grow, len;
    frame  = $urandom();
    height = 16'($urandom_range(16, 4000));
    step   = $urandom_range(1, 3);
    grow   = $urandom_range(0, 40) - 5;
    len    = Depth + $urandom_range(0, 2);
    for (int i = 0; i < len; i++) begin
      send_item(KIND_OBSERVE, id, frame, height);
      frame += step;
      height = 16'(int'(height) + grow + int'($urandom_range(0, noise)));
      if (height == 0) height = 1;
    end
    send_item(KIND_EVALUATE, id, $urandom(), 16'($urandom()));
    count = len + 1;
  endtask

  task automatic test_directed();
    // extremes, zero height, unused kind, absent track
    send_item(KIND_OBSERVE, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000);
    send_item(KIND_EVALUATE, 16'hFFFF, 0, 0);
    send_item(KIND_DROP, 16'hFFFF, 0, 0);
    send_item(2'd3, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF);
    // short history, then wrap of the frame counter and large heights
    for (int i = 0; i < Depth; i++) begin
      send_item(KIND_OBSERVE, 16'h0000, 32'hFFFF_FFFC + i, 16'(16'hF000 + i * 256));
      if (i == 2) send_item(KIND_EVALUATE, 16'h0000, 0, 0);
    end
    send_item(2'd3, 16'h0000, 0, 0);
    send_item(KIND_OBSERVE, 16'h0000, 32'h0000_0004, 16'h0000);
    send_item(KIND_EVALUATE, 16'h0000, 0, 0);
    // flat time: same frame everywhere
    for (int i = 0; i < Depth; i++) send_item(KIND_OBSERVE, 16'h0001, 5, 16'(100 + i));
    send_item(KIND_EVALUATE, 16'h0001, 0, 0);
    // offset saturation and flat height
    for (int i = 0; i < Depth; i++)
      send_item(KIND_OBSERVE, 16'h0002, 32'(i) << 26, 16'h0040);
    send_item(KIND_EVALUATE, 16'h0002, 0, 0);
    send_item(KIND_DROP, 16'h0001, 0, 0);
    send_item(KIND_DROP, 16'h0002, 0, 0);
    send_item(KIND_DROP, 16'h0000, 0, 0);
  endtask

  task automatic test_table_full();
    for (int i = 0; i <= Slots; i++) send_item(KIND_OBSERVE, 16'(i + 100), i, 16'h10);
    send_item(KIND_OBSERVE, 16'd200, 0, 16'h0);
    for (int i = 0; i < Slots; i += 2) send_item(KIND_DROP, 16'(i + 100), 0, 0);
  endtask

  // random sequences under one register setting and handshake profile
  task automatic test_random(input int items, input int idle, input int stall);
    int sent;
    int seq_items;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) < 7) begin
        send_sequence(16'($urandom_range(0, 20)), $urandom_range(0, 1) ? 3 : 200,
                      seq_items);
        sent += seq_items;
      end else begin
        send_item(2'($urandom_range(0, 3)), 16'($urandom_range(0, 20)),
                  $urandom(), $urandom_range(0, 1) ? 16'h0 : 16'($urandom()));
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    rate_q = FRAME_RATE_RST;
    min_fit_q = MIN_FIT_RST;
    for (int i = 0; i < Slots; i++) begin
      used_q[i] = 1'b0;
      count_q[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    drain();
    test_random(330, 0, 0);
    write_reg(CFG_FRAME_RATE, 16'd255);
    write_reg(CFG_MIN_FIT, 16'd0);
    test_random(310, 85, 0);
    write_reg(CFG_FRAME_RATE, 16'd1);
    write_reg(CFG_MIN_FIT, 16'hFFFF);
    test_random(310, 0, 85);
    write_reg(CFG_FRAME_RATE, 16'd0);
    write_reg(CFG_MIN_FIT, 16'd30000);
    test_random(140, 27, 27);
    write_reg(CFG_FRAME_RATE, 16'd60);
    test_random(140, 27, 27);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bhtt_pkg.sv
design/bhtt_ctrl.sv
design/bhtt_dp.sv
design/box_height_ttc_tracker_core.sv
tb/box_height_ttc_tracker_core_tb.sv
